/* rtl/env_sensor_compensation_assert.svh */
// Assertion macros for the environmental compensation block.
`ifndef ENV_SENSOR_COMPENSATION_ASSERT_SVH
`define ENV_SENSOR_COMPENSATION_ASSERT_SVH

// same-cycle implication, off during reset
`define ESC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define ESC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// state right after a reset cycle
`define ESC_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error(msg);

`endif

/* rtl/esc_pkg.sv */
// Shared types and constants of the environmental compensation block.
package esc_pkg;

  localparam int QAW        = 2;
  localparam int QDEPTH     = 1 << QAW;
  localparam int DIV_STEPS  = 64;
  localparam int PIPE_DEPTH = 11 + DIV_STEPS + 6;

  localparam logic [20:0] RAW_P_FULL = 21'd1048576;
  localparam logic [32:0] TF_P_OFS   = 33'd128000;
  localparam logic [31:0] TF_H_OFS   = 32'd76800;
  localparam logic [31:0] T_RND      = 32'd128;
  localparam logic [31:0] HUM_RND    = 32'd16384;
  localparam logic [31:0] U3_OFS     = 32'd32768;
  localparam logic [31:0] U4_OFS     = 32'd2097152;
  localparam logic [31:0] U5_RND     = 32'd8192;
  localparam logic [31:0] HUM_MAX    = 32'd419430400;
  localparam logic [11:0] PRS_SCALE  = 12'd3125;
  localparam logic [63:0] W1_BIAS    = 64'h0000_8000_0000_0000;

  typedef enum logic [2:0] {
    CFG_TEMP     = 3'd0,
    CFG_PRESS_LO = 3'd1,
    CFG_PRESS_HI = 3'd2,
    CFG_PRESS_P9 = 3'd3,
    CFG_HUM      = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
    logic        [7:0]  h1;
    logic signed [15:0] h2;
    logic        [7:0]  h3;
    logic signed [11:0] h4;
    logic signed [11:0] h5;
    logic signed [7:0]  h6;
  } coef_t;

  // request after the front-end pre-subtractions
  typedef struct packed {
    logic [31:0] ta;
    logic [31:0] dt;
    logic [31:0] hpre;
    logic [20:0] padj;
  } fe_t;

  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] tf;
  } kp_t;

  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] tf;
    logic [16:0] hum;
    logic        inv;
  } tail_t;

endpackage

/* rtl/esc_front.sv */
// Front end: strips raw codes and forms the offset terms of each request.
module esc_front (
  input  logic [19:0]   raw_t,
  input  logic [19:0]   raw_p,
  input  logic [15:0]   raw_h,
  input  esc_pkg::coef_t coef,
  output esc_pkg::fe_t   fe
);
  import esc_pkg::*;

  always_comb begin
    fe.ta   = {15'd0, raw_t[19:3]} - {15'd0, coef.t1, 1'b0};
    fe.dt   = {16'd0, raw_t[19:4]} - {16'd0, coef.t1};
    fe.hpre = {2'd0, raw_h, 14'd0} - {coef.h4, 20'd0} + HUM_RND;
    fe.padj = RAW_P_FULL - {1'b0, raw_p};
  end

endmodule

/* rtl/esc_queue.sv */
// Short request queue between the front end and the compute pipeline.
module esc_queue (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  esc_pkg::fe_t din,
  output logic         full,
  input  logic         pop,
  output esc_pkg::fe_t dout,
  output logic         empty
);
  import esc_pkg::*;

  fe_t            mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           wr, rd;

  assign full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rp_r];
  assign wr    = push && !full;
  assign rd    = pop && !empty;

  always_comb begin
    wp_nxt  = wr ? wp_r + 1'b1 : wp_r;
    rp_nxt  = rd ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + {{QAW{1'b0}}, wr} - {{QAW{1'b0}}, rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

/* rtl/esc_back.sv */
// Compute pipeline: temperature, humidity, pressure with a bit-per-stage divider.
module esc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  esc_pkg::coef_t      coef,
  input  esc_pkg::fe_t        fe,
  input  logic                q_empty,
  output logic                q_pop,
  input  logic                out_pop,
  output logic                out_empty,
  output logic signed [31:0]  out_temperature,
  output logic signed [31:0]  out_fine_temperature,
  output logic [31:0]         out_pressure,
  output logic                out_pressure_invalid,
  output logic [16:0]         out_humidity
);
  import esc_pkg::*;

  typedef struct packed {
    logic [30:0] rem;
    logic [63:0] quo;
    logic [30:0] md;
    logic        sgn;
    tail_t       tl;
  } div_t;

  function automatic div_t div_step(input div_t d);
    logic [31:0] t;
    logic [31:0] t_sub;
    logic        ge;
    div_t        o;
    t     = {d.rem, d.quo[63]};
    t_sub = t - {1'b0, d.md};
    ge    = (t >= {1'b0, d.md});
    o     = d;
    o.rem = ge ? t_sub[30:0] : t[30:0];
    o.quo = {d.quo[62:0], ge};
    return o;
  endfunction

  logic adv, take;
  logic [PIPE_DEPTH-1:0] vld_r;
  logic out_v_r;

  assign adv       = !out_v_r || out_pop;
  assign take      = adv && !q_empty;
  assign q_pop     = take;
  assign out_empty = !out_v_r;

  // ---- stage registers
  logic [31:0] ma1_r, mdd1_r, hpre1_r;          logic [20:0] padj1_r;
  logic [31:0] a2_r, mb2_r, hpre2_r;            logic [20:0] padj2_r;
  kp_t kp3_r; logic [32:0] w13_r; logic [31:0] x3_r, hpre3_r; logic [20:0] padj3_r;
  kp_t kp4_r; logic [63:0] sq4_r; logic [48:0] w1p5_4_r, w1p2_4_r;
  logic [31:0] mh5_4_r, mh6_4_r, mh3_4_r, hpre4_r; logic [20:0] padj4_r;
  kp_t kp5_r; logic [48:0] sq6l5_r, sq3l5_r, w1p5_5_r, w1p2_5_r;
  logic [31:0] sq6h5_r, sq3h5_r, u1_5_r, u2_5_r, u3_5_r; logic [20:0] padj5_r;
  kp_t kp6_r; logic [63:0] w2_6_r, sqp3_6_r; logic [48:0] w1p2_6_r;
  logic [31:0] u1_6_r, mu6_r; logic [20:0] padj6_r;
  kp_t kp7_r; logic [63:0] s7_r, diff7_r; logic [31:0] u1_7_r, mh2_7_r;
  kp_t kp8_r; logic [47:0] s1l8_r; logic [31:0] s1h8_r, nh8_r, xx8_r; logic [43:0] nl8_r;
  kp_t kp9_r; logic [30:0] w1f9_r; logic [63:0] num9_r; logic [31:0] xx9_r, hh9_r;
  kp_t kp10_r; logic [63:0] ma10_r; logic [30:0] md10_r; logic sgn10_r, inv10_r;
  logic [31:0] xx10_r, hm10_r;
  div_t s11_r;
  div_t dv_r [DIV_STEPS];
  div_t dv_in [DIV_STEPS];
  div_t dv_nxt [DIV_STEPS];
  tail_t tl0_r, tl1_r, tl2_r, tl3_r, tl4_r, tl5_r;
  logic [63:0] p0_r;
  logic [48:0] m9l1_r, c2l1_r; logic [31:0] m9h1_r, c2h1_r; logic [63:0] ps1_r, pq1_r;
  logic [63:0] m9_2_r, c2_2_r, ps2_r, pq2_r;
  logic [63:0] ll3_r, c2_3_r, pq3_r; logic [31:0] lh3_r, hl3_r;
  logic [63:0] c1_4_r, c2_4_r, pq4_r;
  logic [63:0] sum5_r;

  // ---- next values
  logic [31:0] ma1_nxt, mdd1_nxt, a2_nxt, mb2_nxt, b3, tf3, t5, temp3;
  logic [32:0] w13_nxt; logic [31:0] x3_nxt;
  logic [65:0] sq_full; logic [48:0] w1p5_nxt, w1p2_nxt;
  logic [31:0] mh5_nxt, mh6_nxt, mh3_nxt;
  logic [48:0] sq6l_nxt, sq3l_nxt; logic [31:0] sq6h_nxt, sq3h_nxt;
  logic [31:0] u1d, u1_nxt, u2_nxt, u3a, u3_nxt;
  logic [63:0] w2_nxt, sqp3_nxt, mu6_nxt;
  logic [63:0] sqp3_sh, w1p2x, s7_nxt, diff7_nxt; logic [31:0] u4a, u4, mh2_nxt;
  logic [47:0] s1l_nxt; logic [31:0] s1h_nxt, nh_nxt; logic [43:0] nl_nxt;
  logic [31:0] u5a, u5, xx8_nxt;
  logic [63:0] prod9, num9_nxt; logic [31:0] hs9, hh9_nxt;
  logic [63:0] ma10_nxt; logic [30:0] md10_nxt; logic [31:0] hh7, hm10_nxt;
  logic [31:0] hm4, xh; logic [16:0] hum11; div_t s11_nxt;
  logic [63:0] p0_nxt, ps1_nxt; logic [48:0] m9l_nxt, c2l_nxt; logic [31:0] m9h_nxt, c2h_nxt;
  logic [63:0] m9_nxt, c2s, c2_nxt;
  logic [63:0] ll_nxt; logic [31:0] lh_nxt, hl_nxt;
  logic [63:0] prod4, c1_nxt, sum5_nxt;
  logic [31:0] p7x, pres_nxt;

  always_comb begin
    // temperature
    ma1_nxt  = $signed(fe.ta) * $signed(coef.t2);
    mdd1_nxt = fe.dt * fe.dt;
    a2_nxt   = $signed(ma1_r) >>> 11;
    mb2_nxt  = ($signed(mdd1_r) >>> 12) * $signed(coef.t3);
    b3       = $signed(mb2_r) >>> 14;
    tf3      = a2_r + b3;
    t5       = tf3 * 32'd5 + T_RND;
    temp3    = $signed(t5) >>> 8;
    w13_nxt  = {tf3[31], tf3} - TF_P_OFS;
    x3_nxt   = tf3 - TF_H_OFS;
    // first products
    sq_full  = $signed(w13_r) * $signed(w13_r);
    w1p5_nxt = $signed(w13_r) * $signed(coef.p5);
    w1p2_nxt = $signed(w13_r) * $signed(coef.p2);
    mh5_nxt  = $signed(x3_r) * $signed(coef.h5);
    mh6_nxt  = $signed(x3_r) * $signed(coef.h6);
    mh3_nxt  = x3_r * {24'd0, coef.h3};
    // 64x16 partial products, humidity offsets
    sq6l_nxt = $signed({1'b0, sq4_r[31:0]}) * $signed(coef.p6);
    sq6h_nxt = sq4_r[63:32] * {{16{coef.p6[15]}}, coef.p6};
    sq3l_nxt = $signed({1'b0, sq4_r[31:0]}) * $signed(coef.p3);
    sq3h_nxt = sq4_r[63:32] * {{16{coef.p3[15]}}, coef.p3};
    u1d      = hpre4_r - mh5_4_r;
    u1_nxt   = $signed(u1d) >>> 15;
    u2_nxt   = $signed(mh6_4_r) >>> 10;
    u3a      = $signed(mh3_4_r) >>> 11;
    u3_nxt   = u3a + U3_OFS;
    // sums
    w2_nxt   = {{15{sq6l5_r[48]}}, sq6l5_r} + {sq6h5_r, 32'd0}
             + ({{15{w1p5_5_r[48]}}, w1p5_5_r} << 17)
             + ({{48{coef.p4[15]}}, coef.p4} << 35);
    sqp3_nxt = {{15{sq3l5_r[48]}}, sq3l5_r} + {sq3h5_r, 32'd0};
    mu6_nxt  = {32'd0, u2_5_r * u3_5_r};
    sqp3_sh  = $signed(sqp3_6_r) >>> 8;
    w1p2x    = {{15{w1p2_6_r[48]}}, w1p2_6_r};
    s7_nxt   = sqp3_sh + (w1p2x << 12) + W1_BIAS;
    diff7_nxt = ({43'd0, padj6_r} << 31) - w2_6_r;
    u4a      = $signed(mu6_r[31:0]) >>> 10;
    u4       = u4a + U4_OFS;
    mh2_nxt  = $signed(u4) * $signed(coef.h2);
    s1l_nxt  = s7_r[31:0] * coef.p1;
    s1h_nxt  = s7_r[63:32] * {16'd0, coef.p1};
    nl_nxt   = diff7_r[31:0] * PRS_SCALE;
    nh_nxt   = diff7_r[63:32] * {20'd0, PRS_SCALE};
    u5a      = mh2_7_r + U5_RND;
    u5       = $signed(u5a) >>> 14;
    xx8_nxt  = u1_7_r * u5;
    prod9    = {16'd0, s1l8_r} + {s1h8_r, 32'd0};
    num9_nxt = {20'd0, nl8_r} + {nh8_r, 32'd0};
    hs9      = $signed(xx8_r) >>> 15;
    hh9_nxt  = hs9 * hs9;
    // divider operands
    ma10_nxt = num9_r[63] ? (64'd0 - num9_r) : num9_r;
    md10_nxt = w1f9_r[30] ? (31'd0 - w1f9_r) : w1f9_r;
    hh7      = $signed(hh9_r) >>> 7;
    hm10_nxt = hh7 * {24'd0, coef.h1};
    // humidity clamp
    hm4      = $signed(hm10_r) >>> 4;
    xh       = xx10_r - hm4;
    priority if (xh[31])      hum11 = 17'd0;
    else if (xh > HUM_MAX)    hum11 = HUM_MAX[28:12];
    else                      hum11 = xh[28:12];
    s11_nxt.rem     = '0;
    s11_nxt.quo     = ma10_r;
    s11_nxt.md      = md10_r;
    s11_nxt.sgn     = sgn10_r;
    s11_nxt.tl.temp = kp10_r.temp;
    s11_nxt.tl.tf   = kp10_r.tf;
    s11_nxt.tl.hum  = hum11;
    s11_nxt.tl.inv  = inv10_r;
    // after the divider
    p0_nxt   = dv_r[DIV_STEPS-1].sgn ? (64'd0 - dv_r[DIV_STEPS-1].quo)
                                     : dv_r[DIV_STEPS-1].quo;
    ps1_nxt  = $signed(p0_r) >>> 13;
    m9l_nxt  = $signed(coef.p9) * $signed({1'b0, ps1_nxt[31:0]});
    m9h_nxt  = ps1_nxt[63:32] * {{16{coef.p9[15]}}, coef.p9};
    c2l_nxt  = $signed(coef.p8) * $signed({1'b0, p0_r[31:0]});
    c2h_nxt  = p0_r[63:32] * {{16{coef.p8[15]}}, coef.p8};
    m9_nxt   = {{15{m9l1_r[48]}}, m9l1_r} + {m9h1_r, 32'd0};
    c2s      = {{15{c2l1_r[48]}}, c2l1_r} + {c2h1_r, 32'd0};
    c2_nxt   = $signed(c2s) >>> 19;
    ll_nxt   = m9_2_r[31:0] * ps2_r[31:0];
    lh_nxt   = m9_2_r[31:0] * ps2_r[63:32];
    hl_nxt   = m9_2_r[63:32] * ps2_r[31:0];
    prod4    = ll3_r + {lh3_r + hl3_r, 32'd0};
    c1_nxt   = $signed(prod4) >>> 25;
    sum5_nxt = pq4_r + c1_4_r + c2_4_r;
    p7x      = {{16{coef.p7[15]}}, coef.p7};
    pres_nxt = tl5_r.inv ? 32'd0 : sum5_r[39:8] + {p7x[27:0], 4'd0};
  end

  assign dv_in[0] = s11_r;
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    if (i > 0) begin : g_chain
      assign dv_in[i] = dv_r[i-1];
    end
    assign dv_nxt[i] = div_step(dv_in[i]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      vld_r   <= {vld_r[PIPE_DEPTH-2:0], take};
      out_v_r <= vld_r[PIPE_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ma1_r <= ma1_nxt; mdd1_r <= mdd1_nxt; hpre1_r <= fe.hpre; padj1_r <= fe.padj;
      a2_r <= a2_nxt; mb2_r <= mb2_nxt; hpre2_r <= hpre1_r; padj2_r <= padj1_r;
      kp3_r.temp <= temp3; kp3_r.tf <= tf3; w13_r <= w13_nxt; x3_r <= x3_nxt;
      hpre3_r <= hpre2_r; padj3_r <= padj2_r;
      kp4_r <= kp3_r; sq4_r <= sq_full[63:0]; w1p5_4_r <= w1p5_nxt; w1p2_4_r <= w1p2_nxt;
      mh5_4_r <= mh5_nxt; mh6_4_r <= mh6_nxt; mh3_4_r <= mh3_nxt;
      hpre4_r <= hpre3_r; padj4_r <= padj3_r;
      kp5_r <= kp4_r; sq6l5_r <= sq6l_nxt; sq6h5_r <= sq6h_nxt;
      sq3l5_r <= sq3l_nxt; sq3h5_r <= sq3h_nxt; w1p5_5_r <= w1p5_4_r; w1p2_5_r <= w1p2_4_r;
      u1_5_r <= u1_nxt; u2_5_r <= u2_nxt; u3_5_r <= u3_nxt; padj5_r <= padj4_r;
      kp6_r <= kp5_r; w2_6_r <= w2_nxt; sqp3_6_r <= sqp3_nxt; w1p2_6_r <= w1p2_5_r;
      u1_6_r <= u1_5_r; mu6_r <= mu6_nxt[31:0]; padj6_r <= padj5_r;
      kp7_r <= kp6_r; s7_r <= s7_nxt; diff7_r <= diff7_nxt;
      u1_7_r <= u1_6_r; mh2_7_r <= mh2_nxt;
      kp8_r <= kp7_r; s1l8_r <= s1l_nxt; s1h8_r <= s1h_nxt; nl8_r <= nl_nxt;
      nh8_r <= nh_nxt; xx8_r <= xx8_nxt;
      kp9_r <= kp8_r; w1f9_r <= prod9[63:33]; num9_r <= num9_nxt;
      xx9_r <= xx8_r; hh9_r <= hh9_nxt;
      kp10_r <= kp9_r; ma10_r <= ma10_nxt; md10_r <= md10_nxt;
      sgn10_r <= num9_r[63] ^ w1f9_r[30]; inv10_r <= (w1f9_r == '0);
      xx10_r <= xx9_r; hm10_r <= hm10_nxt;
      s11_r <= s11_nxt;
      dv_r <= dv_nxt;
      tl0_r <= dv_r[DIV_STEPS-1].tl; p0_r <= p0_nxt;
      tl1_r <= tl0_r; m9l1_r <= m9l_nxt; m9h1_r <= m9h_nxt;
      c2l1_r <= c2l_nxt; c2h1_r <= c2h_nxt; ps1_r <= ps1_nxt; pq1_r <= p0_r;
      tl2_r <= tl1_r; m9_2_r <= m9_nxt; c2_2_r <= c2_nxt; ps2_r <= ps1_r; pq2_r <= pq1_r;
      tl3_r <= tl2_r; ll3_r <= ll_nxt; lh3_r <= lh_nxt; hl3_r <= hl_nxt;
      c2_3_r <= c2_2_r; pq3_r <= pq2_r;
      tl4_r <= tl3_r; c1_4_r <= c1_nxt; c2_4_r <= c2_3_r; pq4_r <= pq3_r;
      tl5_r <= tl4_r; sum5_r <= sum5_nxt;
      out_temperature      <= tl5_r.temp;
      out_fine_temperature <= tl5_r.tf;
      out_pressure         <= pres_nxt;
      out_pressure_invalid <= tl5_r.inv;
      out_humidity         <= tl5_r.hum;
    end
  end

endmodule

/* rtl/env_sensor_compensation.sv */
// Top level of the environmental sensor compensation block.
// Usage:
//  - Input channel: drive in_raw_* with a measurement burst and raise
//    in_push; the request is taken on a clock edge where in_full is low.
//  - Result channel: while out_empty is low the oldest result sits on the
//    out_* ports; raise out_pop to take it on that edge.
//  - Calibration: write registers through cfg_wr_en/cfg_index/cfg_wdata
//    while no request is in flight. Unknown indexes are dropped.
//  - Throughput: one request per cycle, sustained while no result waits at
//    the output. The pressure path runs through the 64-stage restoring
//    divider plus the multiply stages around it (no product wider than
//    33x33 per stage).
//  - Stall: while a result waits, the whole compute pipeline freezes; the
//    4-entry request queue keeps taking requests until in_full rises.
//  - Reset (synchronous, rst_n low): queue and pipeline emptied,
//    calibration registers cleared to zero.
//  - A zero pressure divisor gives pressure 0 with pressure_invalid set.
module env_sensor_compensation (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [19:0]        in_raw_temperature,
  input  logic [19:0]        in_raw_pressure,
  input  logic [15:0]        in_raw_humidity,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [31:0] out_temperature,
  output logic signed [31:0] out_fine_temperature,
  output logic [31:0]        out_pressure,
  output logic               out_pressure_invalid,
  output logic [16:0]        out_humidity,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_wdata
);
  import esc_pkg::*;

  // calibration registers
  logic [47:0] temp_r;
  logic [63:0] plo_r, phi_r, hum_r;
  logic [15:0] p9_r;
  coef_t       coef;

  fe_t  fe_in, fe_q;
  logic q_empty, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_r <= '0;
      plo_r  <= '0;
      phi_r  <= '0;
      p9_r   <= '0;
      hum_r  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TEMP:     temp_r <= cfg_wdata[47:0];
        CFG_PRESS_LO: plo_r  <= cfg_wdata;
        CFG_PRESS_HI: phi_r  <= cfg_wdata;
        CFG_PRESS_P9: p9_r   <= cfg_wdata[15:0];
        CFG_HUM:      hum_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // unpack coefficient fields
  always_comb begin
    coef.t1 = temp_r[15:0];
    coef.t2 = temp_r[31:16];
    coef.t3 = temp_r[47:32];
    coef.p1 = plo_r[15:0];
    coef.p2 = plo_r[31:16];
    coef.p3 = plo_r[47:32];
    coef.p4 = plo_r[63:48];
    coef.p5 = phi_r[15:0];
    coef.p6 = phi_r[31:16];
    coef.p7 = phi_r[47:32];
    coef.p8 = phi_r[63:48];
    coef.p9 = p9_r;
    coef.h1 = hum_r[7:0];
    coef.h2 = hum_r[23:8];
    coef.h3 = hum_r[31:24];
    coef.h4 = hum_r[43:32];
    coef.h5 = hum_r[55:44];
    coef.h6 = hum_r[63:56];
  end

  esc_front u_front (
    .raw_t (in_raw_temperature),
    .raw_p (in_raw_pressure),
    .raw_h (in_raw_humidity),
    .coef  (coef),
    .fe    (fe_in)
  );

  esc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .din   (fe_in),
    .full  (in_full),
    .pop   (q_pop),
    .dout  (fe_q),
    .empty (q_empty)
  );

  esc_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .coef                 (coef),
    .fe                   (fe_q),
    .q_empty              (q_empty),
    .q_pop                (q_pop),
    .out_pop              (out_pop),
    .out_empty            (out_empty),
    .out_temperature      (out_temperature),
    .out_fine_temperature (out_fine_temperature),
    .out_pressure         (out_pressure),
    .out_pressure_invalid (out_pressure_invalid),
    .out_humidity         (out_humidity)
  );

endmodule

/* rtl/env_sensor_compensation_chk.sv */
// Port-level checker for the compensation block, bound to the top level.
`include "env_sensor_compensation_assert.svh"

module env_sensor_compensation_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_push,
  input logic               in_full,
  input logic [19:0]        in_raw_temperature,
  input logic [19:0]        in_raw_pressure,
  input logic [15:0]        in_raw_humidity,
  input logic               out_empty,
  input logic               out_pop,
  input logic signed [31:0] out_temperature,
  input logic signed [31:0] out_fine_temperature,
  input logic [31:0]        out_pressure,
  input logic               out_pressure_invalid,
  input logic [16:0]        out_humidity,
  input logic               cfg_wr_en,
  input logic [2:0]         cfg_index,
  input logic [63:0]        cfg_wdata
);
  logic [31:0]        t5_chk;
  logic signed [31:0] temp_chk;

  assign t5_chk   = out_fine_temperature * 32'sd5 + 32'sd128;
  assign temp_chk = $signed(t5_chk) >>> 8;

  `ESC_ASSERT_RST(a_rst_empty, out_empty && !in_full, "not empty after reset")
  `ESC_ASSERT_NXT(a_hold, !out_empty && !out_pop, !out_empty && $stable(out_pressure) && $stable(out_humidity), "stalled result changed")
  `ESC_ASSERT_IMP(a_inv_zero, !out_empty && out_pressure_invalid, out_pressure == 32'd0, "invalid pressure not zero")
  `ESC_ASSERT_IMP(a_hum_max, !out_empty, out_humidity <= 17'd102400, "humidity above clamp")
  `ESC_ASSERT_IMP(a_temp_fine, !out_empty, out_temperature == temp_chk, "temperature mismatches fine value")

endmodule

bind env_sensor_compensation env_sensor_compensation_chk u_chk (.*);
